@@ sv/jpsi_pkg.sv @@
`timescale 1ns / 1ps

package jpsi_pkg;

  // field widths
  localparam int JIDX_W  = 5;
  localparam int Q_W     = 32;
  localparam int GAIN_W  = 31;
  localparam int STEPS_W = 11;
  localparam int RATE_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // joint count default, legal range 1..32
  localparam int JOINTS_DEF = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERP_STEPS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_RATE = 1'd1;

  localparam logic [STEPS_W-1:0] INTERP_STEPS_RST = 11'd1;
  localparam logic [RATE_W-1:0]  CONTROL_RATE_RST = 16'd200;

  // item modes
  localparam logic MODE_CONTROL = 1'b0;
  localparam logic MODE_CAPTURE = 1'b1;

  // divider: 33-bit magnitude over an 11-bit step count
  localparam int DIV_N_W   = 33;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  // shared multiplier: 33-bit signed by 16-bit unsigned
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD,
    ST_DIVST,
    ST_DIV,
    ST_CMD,
    ST_CMDQ,
    ST_MUL,
    ST_SUM,
    ST_CLAMP,
    ST_DONE
  } state_t;

endpackage

@@ sv/jpsi_if.sv @@
`timescale 1ns / 1ps

interface jpsi_samp_if;
  logic                                valid;
  logic                                ready;
  logic                                mode;
  logic [jpsi_pkg::JIDX_W-1:0]         joint_index;
  logic signed [jpsi_pkg::Q_W-1:0]     measured_pos;
  logic signed [jpsi_pkg::Q_W-1:0]     target_pos;
  logic                                ref_is_new;
  logic                                torque_mode;
  logic signed [jpsi_pkg::Q_W-1:0]     ref_torque;
  logic [jpsi_pkg::GAIN_W-1:0]         p_gain;
  logic [jpsi_pkg::GAIN_W-1:0]         d_gain;
  logic [jpsi_pkg::GAIN_W-1:0]         torque_cap;
  logic                                tick_end;

  modport source (
    output valid, mode, joint_index, measured_pos, target_pos, ref_is_new,
           torque_mode, ref_torque, p_gain, d_gain, torque_cap, tick_end,
    input  ready
  );
  modport sink (
    input  valid, mode, joint_index, measured_pos, target_pos, ref_is_new,
           torque_mode, ref_torque, p_gain, d_gain, torque_cap, tick_end,
    output ready
  );
endinterface

interface jpsi_drive_if;
  logic                            valid;
  logic                            ready;
  logic [jpsi_pkg::JIDX_W-1:0]     out_joint;
  logic signed [jpsi_pkg::Q_W-1:0] drive_torque;
  logic                            was_clamped;

  modport source (output valid, out_joint, drive_torque, was_clamped, input ready);
  modport sink (input valid, out_joint, drive_torque, was_clamped, output ready);
endinterface

@@ sv/jpsi_ram.sv @@
`timescale 1ns / 1ps

module jpsi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/jpsi_div.sv @@
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module jpsi_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [jpsi_pkg::DIV_N_W-1:0]      dividend,
  input  logic [jpsi_pkg::STEPS_W-1:0]      divisor,
  output logic [jpsi_pkg::DIV_N_W-1:0]      quo,
  output jpsi_pkg::div_stat_t               stat
);

  localparam int N = jpsi_pkg::DIV_N_W;
  localparam int D = jpsi_pkg::STEPS_W;
  localparam int CW = jpsi_pkg::DIV_CNT_W;

  logic          busy;
  logic [CW-1:0] cnt;
  logic [D-1:0]  rem;
  logic [N-1:0]  sh;
  logic [D:0]    trial;
  logic          qbit;
  logic [D:0]    trial_sub;

  assign trial     = {rem, sh[N-1]};
  assign qbit      = (trial >= {1'b0, divisor});
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(N);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[N-2:0], qbit};
      rem <= qbit ? trial_sub[D-1:0] : trial[D-1:0];
    end
  end

  assign quo       = sh;
  assign stat.busy = busy;
  assign stat.done = busy && (cnt == CW'(1));

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy && (cnt == CW'(N)))
    else $error("divider did not start");

  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(stat.done))
    else $error("divider stopped early");

endmodule

@@ sv/jpsi_mul.sv @@
`timescale 1ns / 1ps

// shared signed-by-unsigned multiplier, product registered
module jpsi_mul (
  input  logic                                  clk,
  input  logic signed [jpsi_pkg::MUL_A_W-1:0]   a,
  input  logic [jpsi_pkg::MUL_B_W-1:0]          b,
  output logic signed [jpsi_pkg::PROD_W-1:0]    prod
);

  logic signed [jpsi_pkg::MUL_B_W:0] b_s;

  assign b_s = $signed({1'b0, b});

  always_ff @(posedge clk) begin
    prod <= a * b_s;
  end

endmodule

@@ sv/joint_pd_servo_interp.sv @@
// Per-joint PD servo with reference interpolation and torque clamp.
// A control word passes read, load, divider start, the 33-step restoring
// divider (skipped with zero steps left), command, multiply, sum, clamp, done;
// a capture word goes to clamp and done. New words are taken only in idle.
// Reset (rst, sync, high) clears the sequencer and output valid, loads
// interp_steps=1, control_rate_hz=200, steps_left=1; joint history is unset.
`timescale 1ns / 1ps

module joint_pd_servo_interp #(
  parameter int JOINTS = jpsi_pkg::JOINTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  jpsi_samp_if.sink                          samp,
  jpsi_drive_if.source                       drive,
  input  logic                               cfg_we,
  input  logic [jpsi_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [jpsi_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int AW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int QW   = jpsi_pkg::Q_W;
  localparam int SW   = jpsi_pkg::STEPS_W;
  localparam int RW   = jpsi_pkg::RATE_W;
  localparam int GW   = jpsi_pkg::GAIN_W;
  localparam int JW   = jpsi_pkg::JIDX_W;
  localparam int PW   = jpsi_pkg::PROD_W;
  localparam int AC_W = 64;       // one gain product, exact
  localparam int TW   = 49;       // sum of two floored Q16.16 terms

  // saturate a multiplier product to the signed 32-bit range
  function automatic logic signed [QW-1:0] sat32(input logic signed [PW-1:0] v);
    logic signed [QW-1:0] r;
    if (v > $signed(PW'(32'sh7fffffff)))       r = 32'sh7fffffff;
    else if (v < $signed(-PW'(64'sh80000000))) r = 32'sh80000000;
    else                                        r = v[QW-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------
  logic [SW-1:0] interp_steps;
  logic [RW-1:0] control_rate_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_steps    <= jpsi_pkg::INTERP_STEPS_RST;
      control_rate_hz <= jpsi_pkg::CONTROL_RATE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        jpsi_pkg::REG_INTERP_STEPS: interp_steps    <= cfg_wdata[SW-1:0];
        jpsi_pkg::REG_CONTROL_RATE: control_rate_hz <= cfg_wdata[RW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------
  jpsi_pkg::state_t state, state_next;
  logic             accept;
  logic             div_start;
  logic             ram_we;
  logic             load_out;
  logic [2:0]       mul_k;           // multiplier op index, 0..6
  logic             out_valid;
  jpsi_pkg::div_stat_t div_st;

  // latched word
  logic                 mode_r;
  logic [JW-1:0]        j_r;
  logic signed [QW-1:0] q_r;
  logic signed [QW-1:0] r_r;
  logic                 tmode_r;
  logic signed [QW-1:0] rtau_r;
  logic [GW-1:0]        pg_r;
  logic [GW-1:0]        dg_r;
  logic [GW-1:0]        cap_r;
  logic                 tend_r;
  logic [SW-1:0]        steps_left;
  logic                 jvalid;

  assign accept = samp.valid && samp.ready;
  assign jvalid = (7'(j_r) < 7'(JOINTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jpsi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      jpsi_pkg::ST_IDLE: begin
        if (samp.valid) begin
          state_next = (samp.mode == jpsi_pkg::MODE_CAPTURE) ?
                       jpsi_pkg::ST_CLAMP : jpsi_pkg::ST_READ;
        end
      end
      jpsi_pkg::ST_READ:  state_next = jpsi_pkg::ST_LOAD;
      jpsi_pkg::ST_LOAD:  state_next = jpsi_pkg::ST_DIVST;
      jpsi_pkg::ST_DIVST: begin
        state_next = (steps_left == '0) ? jpsi_pkg::ST_CMD : jpsi_pkg::ST_DIV;
      end
      jpsi_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_next = jpsi_pkg::ST_CMD;
        end
      end
      jpsi_pkg::ST_CMD:  state_next = jpsi_pkg::ST_CMDQ;
      jpsi_pkg::ST_CMDQ: state_next = jpsi_pkg::ST_MUL;
      jpsi_pkg::ST_MUL: begin
        if (mul_k == 3'd6) begin
          state_next = jpsi_pkg::ST_SUM;
        end
      end
      jpsi_pkg::ST_SUM:   state_next = jpsi_pkg::ST_CLAMP;
      jpsi_pkg::ST_CLAMP: state_next = jpsi_pkg::ST_DONE;
      jpsi_pkg::ST_DONE: begin
        if (!out_valid || drive.ready) begin
          state_next = jpsi_pkg::ST_IDLE;
        end
      end
      default: state_next = jpsi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    samp.ready = 1'b0;
    div_start  = 1'b0;
    ram_we     = 1'b0;
    load_out   = 1'b0;
    case (state)
      jpsi_pkg::ST_IDLE:  samp.ready = 1'b1;
      jpsi_pkg::ST_DIVST: div_start  = (steps_left != '0);
      jpsi_pkg::ST_CLAMP: ram_we     = jvalid;
      jpsi_pkg::ST_DONE:  load_out   = !out_valid || drive.ready;
      default: ;
    endcase
  end

  // steps_left: reload on a new reference at accept, count down at the
  // last joint of a tick, floor at zero
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_left <= jpsi_pkg::INTERP_STEPS_RST;
    end else if (accept && samp.ref_is_new) begin
      steps_left <= interp_steps;
    end else if (state == jpsi_pkg::ST_CLAMP && tend_r && steps_left != '0) begin
      steps_left <= steps_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_k <= '0;
    end else if (state == jpsi_pkg::ST_MUL) begin
      mul_k <= mul_k + 1'b1;
    end else begin
      mul_k <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= samp.mode;
      j_r     <= samp.joint_index;
      q_r     <= samp.measured_pos;
      r_r     <= samp.target_pos;
      tmode_r <= samp.torque_mode;
      rtau_r  <= samp.ref_torque;
      pg_r    <= samp.p_gain;
      dg_r    <= samp.d_gain;
      cap_r   <= samp.torque_cap;
      tend_r  <= samp.tick_end;
    end
  end

  // --------------------------------------------------------------------
  // joint history: previous position and previous command
  // --------------------------------------------------------------------
  logic [QW-1:0] pp_rd;
  logic [QW-1:0] pc_rd;
  logic [QW-1:0] cmd_wd;
  logic signed [QW-1:0] cmd_r;

  assign cmd_wd = (mode_r == jpsi_pkg::MODE_CAPTURE) ? q_r : cmd_r;

  jpsi_ram #(.WIDTH(QW), .DEPTH(JOINTS)) u_pos_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(j_r)),
    .wdata (q_r),
    .raddr (AW'(j_r)),
    .rdata (pp_rd)
  );

  jpsi_ram #(.WIDTH(QW), .DEPTH(JOINTS)) u_cmd_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(j_r)),
    .wdata (cmd_wd),
    .raddr (AW'(j_r)),
    .rdata (pc_rd)
  );

  // --------------------------------------------------------------------
  // interpolation step: cmd = pc + (r - pc) / steps_left, toward zero
  // --------------------------------------------------------------------
  logic signed [QW-1:0] pc_r;
  logic signed [QW:0]   diff_r;     // r - pc
  logic signed [QW:0]   dq_r;       // q - pp
  logic                 neg_r;
  logic [QW:0]          div_mag;
  logic [QW:0]          quo;
  logic signed [QW:0]   delta_r;    // cmd - pc

  assign div_mag = diff_r[QW] ? (QW+1)'(0) - diff_r : diff_r;

  jpsi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_mag),
    .divisor  (steps_left),
    .quo      (quo),
    .stat     (div_st)
  );

  // --------------------------------------------------------------------
  // shared multiplier, op k issued at mul_k == k, consumed at k + 1
  //   0: delta * rate        1: (q - pp) * rate
  //   2,3: e * p_gain lo/hi  4,5: ev * d_gain lo/hi
  // --------------------------------------------------------------------
  logic signed [QW:0]   e_r;        // cmd - q
  logic signed [QW:0]   ev_r;       // vcmd - vmeas
  logic signed [QW-1:0] vcmd_r;
  logic signed [QW-1:0] vmeas_r;
  logic signed [QW:0]   mul_a;
  logic [RW-1:0]        mul_b;
  logic signed [PW-1:0] prod;
  logic signed [AC_W-1:0] prod_ext;
  logic signed [AC_W-1:0] prod_hi;
  logic signed [AC_W-1:0] acc;
  logic signed [TW-1:0]   tsum;
  logic signed [TW-1:0]   acc_fl;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mul_k)
      3'd0: begin mul_a = delta_r; mul_b = control_rate_hz; end
      3'd1: begin mul_a = dq_r;    mul_b = control_rate_hz; end
      3'd2: begin mul_a = e_r;     mul_b = pg_r[RW-1:0]; end
      3'd3: begin mul_a = e_r;     mul_b = RW'(pg_r[GW-1:RW]); end
      3'd4: begin mul_a = ev_r;    mul_b = dg_r[RW-1:0]; end
      3'd5: begin mul_a = ev_r;    mul_b = RW'(dg_r[GW-1:RW]); end
      default: ;
    endcase
  end

  jpsi_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_ext = AC_W'(prod);
  assign prod_hi  = {prod_ext[AC_W-17:0], 16'd0};
  // floor(acc / 2^16)
  assign acc_fl   = {acc[AC_W-1], acc[AC_W-1:16]};

  // --------------------------------------------------------------------
  // clamp
  // --------------------------------------------------------------------
  logic signed [TW-1:0] tau;
  logic signed [TW-1:0] cap_p;
  logic signed [TW-1:0] cap_n;
  logic signed [QW-1:0] res_torque;
  logic                 res_clamped;

  assign tau   = tmode_r ? TW'(rtau_r) : tsum;
  assign cap_p = $signed({18'd0, cap_r});
  assign cap_n = -cap_p;

  always_comb begin
    res_torque  = tau[QW-1:0];
    res_clamped = 1'b0;
    if (mode_r == jpsi_pkg::MODE_CAPTURE) begin
      res_torque = '0;
    end else if (tau > cap_p) begin
      res_torque  = cap_p[QW-1:0];
      res_clamped = 1'b1;
    end else if (tau < cap_n) begin
      res_torque  = cap_n[QW-1:0];
      res_clamped = 1'b1;
    end
  end

  logic signed [QW-1:0] res_torque_r;
  logic                 res_clamped_r;

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      jpsi_pkg::ST_LOAD: begin
        pc_r   <= jvalid ? $signed(pc_rd) : '0;
        diff_r <= (QW+1)'(r_r) - (QW+1)'(jvalid ? $signed(pc_rd) : QW'(0));
        dq_r   <= (QW+1)'(q_r) - (QW+1)'(jvalid ? $signed(pp_rd) : QW'(0));
        neg_r  <= 1'b0;
      end
      jpsi_pkg::ST_DIVST: neg_r <= diff_r[QW];
      jpsi_pkg::ST_CMD: begin
        if (steps_left == '0) begin
          delta_r <= '0;
        end else begin
          delta_r <= neg_r ? (QW+1)'(0) - $signed(quo) : $signed(quo);
        end
      end
      jpsi_pkg::ST_CMDQ: cmd_r <= pc_r + delta_r[QW-1:0];
      jpsi_pkg::ST_MUL: begin
        case (mul_k)
          3'd0: e_r     <= (QW+1)'(cmd_r) - (QW+1)'(q_r);
          3'd1: vcmd_r  <= sat32(prod);
          3'd2: vmeas_r <= sat32(prod);
          3'd3: begin
            acc  <= prod_ext;
            ev_r <= (QW+1)'(vcmd_r) - (QW+1)'(vmeas_r);
          end
          3'd4: acc <= acc + prod_hi;
          3'd5: begin
            tsum <= acc_fl;
            acc  <= prod_ext;
          end
          3'd6: acc <= acc + prod_hi;
          default: ;
        endcase
      end
      jpsi_pkg::ST_SUM: tsum <= tsum + acc_fl;
      jpsi_pkg::ST_CLAMP: begin
        res_torque_r  <= res_torque;
        res_clamped_r <= res_clamped;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------
  // result register: frees the sequencer while the word waits
  // --------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (drive.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      drive.out_joint    <= j_r;
      drive.drive_torque <= res_torque_r;
      drive.was_clamped  <= res_clamped_r;
    end
  end

  assign drive.valid = out_valid;

  // --------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------
  a_reload: assert property (@(posedge clk) disable iff (rst)
    accept && samp.ref_is_new |=> steps_left == $past(interp_steps))
    else $error("steps_left not reloaded");

  a_steps_down: assert property (@(posedge clk) disable iff (rst)
    !(accept && samp.ref_is_new) |=> steps_left <= $past(steps_left))
    else $error("steps_left grew without reload");

  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    state == jpsi_pkg::ST_DIV |-> div_st.busy)
    else $error("waiting on idle divider");

  a_one_word: assert property (@(posedge clk) disable iff (rst)
    load_out |-> !out_valid || drive.ready)
    else $error("result overwritten");

endmodule

@@ bench/joint_pd_servo_interp_tb.sv @@
`timescale 1ns / 1ps

module joint_pd_servo_interp_tb;

  localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int HOLD_OFF    = 400;   // long output stall, fills the servo
  localparam int TAIL_CYCLES = 64;    // outlasts a control word's pass through the servo
  localparam int PHASE_WORDS = 136;
  localparam int NJ          = 32;
  localparam int JW          = jpsi_pkg::JIDX_W;
  localparam int GW          = jpsi_pkg::GAIN_W;

  // one joint sample as the sender offers it
  typedef struct {
    logic               mode;
    logic [JW-1:0]      joint;
    logic signed [31:0] meas;
    logic signed [31:0] target;
    logic               ref_new;
    logic               tmode;
    logic signed [31:0] ref_tau;
    logic [GW-1:0]      pg;
    logic [GW-1:0]      dg;
    logic [GW-1:0]      cap;
    logic               tick_end;
  } sample_t;

  // one torque word as the servo should emit it
  typedef struct packed {
    logic [JW-1:0]      joint;
    logic signed [31:0] torque;
    logic               clamped;
  } torque_word_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [jpsi_pkg::CFG_IDX_W-1:0]    cfg_idx;
  logic [jpsi_pkg::CFG_W-1:0]        cfg_wdata;

  jpsi_samp_if  samp_if ();
  jpsi_drive_if drive_if ();

  joint_pd_servo_interp dut (
    .clk       (clk),
    .rst       (rst),
    .samp      (samp_if),
    .drive     (drive_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Servo shadow state: joint history, interpolation counter, register copies.
  // Updated in acceptance order, so it always matches what the DUT should see.
  // ---------------------------------------------------------------------------
  logic signed [31:0] pos_hist   [NJ];
  logic signed [31:0] cmd_hist   [NJ];
  logic               hist_valid [NJ];   // joint history written since reset
  logic [jpsi_pkg::STEPS_W-1:0] steps_remaining;
  logic [jpsi_pkg::STEPS_W-1:0] interp_steps_set;
  logic [jpsi_pkg::RATE_W-1:0]  rate_set;
  logic signed [31:0] goal_pos   [NJ];   // per-joint reference for random ticks

  torque_word_t torque_due [$];          // torques owed by the DUT, oldest first

  int mismatches;
  int n_control, n_capture, n_clamped, n_settings;
  int hold_order;                        // handed to the output sink, which counts it down
  int burst_left;
  bit gaps_on;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint sat32(input longint v);
    if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
    if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
    return v;
  endfunction

  // Works out the torque word for one accepted sample and advances the shadow
  // state. Positions are sign-extended to 64 bits; gains stay unsigned.
  function automatic torque_word_t servo_predict(input sample_t s);
    torque_word_t w;
    longint q, r, pc, pp, cmd, vcmd, vmeas, tau, cap, rate;
    w.joint   = s.joint;
    w.torque  = '0;
    w.clamped = 1'b0;
    // reload happens before the sample is handled, capture words included
    if (s.ref_new) steps_remaining = interp_steps_set;
    if (s.mode == jpsi_pkg::MODE_CAPTURE) begin
      pos_hist[s.joint]   = s.meas;
      cmd_hist[s.joint]   = s.meas;
      hist_valid[s.joint] = 1'b1;
      n_capture++;
    end else begin
      q    = s.meas;
      r    = s.target;
      pc   = cmd_hist[s.joint];
      pp   = pos_hist[s.joint];
      rate = longint'(rate_set);
      // one interpolation step, truncated toward zero; holds once steps run out
      if (steps_remaining != '0) cmd = pc + (r - pc) / longint'(steps_remaining);
      else cmd = pc;
      vcmd  = sat32((cmd - pc) * rate);
      vmeas = sat32((q - pp) * rate);
      if (s.tmode) tau = s.ref_tau;
      else tau = ((longint'(s.pg) * (cmd - q)) >>> 16)
               + ((longint'(s.dg) * (vcmd - vmeas)) >>> 16);
      cap = longint'(s.cap);
      if (tau > cap) begin
        tau = cap;
        w.clamped = 1'b1;
      end else if (tau < -cap) begin
        tau = -cap;
        w.clamped = 1'b1;
      end
      w.torque = tau[31:0];
      pos_hist[s.joint]   = q[31:0];
      cmd_hist[s.joint]   = cmd[31:0];
      hist_valid[s.joint] = 1'b1;
      n_control++;
      if (w.clamped) n_clamped++;
    end
    if (s.tick_end && steps_remaining != '0) steps_remaining = steps_remaining - 1'b1;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample side
  // ---------------------------------------------------------------------------

  // Offers one word and holds it until taken. In burst mode the sender drops
  // valid for a random gap at the end of each burst.
  task automatic send_word(input sample_t s);
    samp_if.valid       <= 1'b1;
    samp_if.mode        <= s.mode;
    samp_if.joint_index <= s.joint;
    samp_if.measured_pos <= s.meas;
    samp_if.target_pos  <= s.target;
    samp_if.ref_is_new  <= s.ref_new;
    samp_if.torque_mode <= s.tmode;
    samp_if.ref_torque  <= s.ref_tau;
    samp_if.p_gain      <= s.pg;
    samp_if.d_gain      <= s.dg;
    samp_if.torque_cap  <= s.cap;
    samp_if.tick_end    <= s.tick_end;
    do @(posedge clk); while (!samp_if.ready);
    torque_due.push_back(servo_predict(s));
    if (gaps_on) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        burst_left = $urandom_range(0, 12);
        samp_if.valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(posedge clk);
      end
    end
  endtask

  // Sender stops and waits until every owed torque word has come back.
  task automatic await_idle();
    samp_if.valid <= 1'b0;
    while (torque_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Both registers in two back-to-back writes; only called with the servo idle.
  task automatic load_servo_config(input int unsigned steps, input int unsigned rate);
    cfg_we    <= 1'b1;
    cfg_idx   <= jpsi_pkg::REG_INTERP_STEPS;
    cfg_wdata <= jpsi_pkg::CFG_W'(steps);
    @(posedge clk);
    interp_steps_set = steps[jpsi_pkg::STEPS_W-1:0];
    cfg_idx   <= jpsi_pkg::REG_CONTROL_RATE;
    cfg_wdata <= jpsi_pkg::CFG_W'(rate);
    @(posedge clk);
    rate_set = rate[jpsi_pkg::RATE_W-1:0];
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic sample_t plain_word(input logic m, input logic [JW-1:0] j);
    sample_t s;
    s.mode = m;     s.joint = j;    s.meas = '0;   s.target = '0;
    s.ref_new = 0;  s.tmode = 0;    s.ref_tau = '0;
    s.pg = '0;      s.dg = '0;      s.cap = '0;    s.tick_end = 0;
    return s;
  endfunction

  function automatic logic signed [31:0] near_pos(input logic signed [31:0] x);
    logic signed [31:0] off;
    off = $urandom_range(0, 32'h001F_FFFF);
    return x + off - 32'sh0010_0000;   // within +/-16 rad, wraps at the rails
  endfunction

  function automatic logic [GW-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return GW'($urandom);
      default: return GW'($urandom_range(0, 32'h0004_0000));  // up to 4.0
    endcase
  endfunction

  function automatic logic [GW-1:0] pick_cap();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return GW'($urandom);
      default: return GW'($urandom_range(0, 32'h0100_0000));
    endcase
  endfunction

  function automatic sample_t capture_word(input logic [JW-1:0] j);
    sample_t s;
    s = plain_word(jpsi_pkg::MODE_CAPTURE, j);
    // fields a capture ignores still get random bits
    s.meas     = ($urandom_range(0, 3) == 0) ? 32'($urandom) : near_pos(cmd_hist[j]);
    s.target   = $urandom;
    s.ref_tau  = $urandom;
    s.tmode    = $urandom_range(0, 1);
    s.pg       = GW'($urandom);
    s.dg       = GW'($urandom);
    s.cap      = GW'($urandom);
    s.ref_new  = ($urandom_range(0, 5) == 0);
    s.tick_end = ($urandom_range(0, 5) == 0);
    return s;
  endfunction

  // One joint of a control tick; a joint with no history gets captured first.
  function automatic sample_t tick_word(input logic [JW-1:0] j, input logic first,
                                        input logic last);
    sample_t s;
    if (!hist_valid[j]) return capture_word(j);
    s = plain_word(jpsi_pkg::MODE_CONTROL, j);
    s.meas     = near_pos(cmd_hist[j]);
    s.target   = goal_pos[j];
    s.ref_new  = first;
    s.tmode    = ($urandom_range(0, 7) == 0);
    s.ref_tau  = $urandom;
    s.pg       = pick_gain();
    s.dg       = pick_gain();
    s.cap      = pick_cap();
    s.tick_end = last;
    return s;
  endfunction

  function automatic sample_t noise_word();
    sample_t s;
    s.mode     = $urandom_range(0, 1);
    s.joint    = $urandom_range(0, NJ - 1);
    s.meas     = $urandom;
    s.target   = $urandom;
    s.ref_new  = $urandom_range(0, 1);
    s.tmode    = $urandom_range(0, 1);
    s.ref_tau  = $urandom;
    s.pg       = GW'($urandom);
    s.dg       = GW'($urandom);
    s.cap      = GW'($urandom);
    s.tick_end = $urandom_range(0, 1);
    if (!hist_valid[s.joint]) s.mode = jpsi_pkg::MODE_CAPTURE;
    return s;
  endfunction

  // Mostly well-formed reference periods: a small joint group ticked a few
  // times, reload on the first word, tick end on the last joint of each tick.
  // The rest is lone captures and fully random noise.
  task automatic random_phase(input int n_words);
    int sent, k, base_j, n_ticks, t, i;
    logic [JW-1:0] j;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 9))
        0: begin
          send_word(noise_word());
          sent++;
        end
        1: begin
          send_word(capture_word($urandom_range(0, NJ - 1)));
          sent++;
        end
        default: begin
          k       = $urandom_range(1, 4);
          base_j  = $urandom_range(0, NJ - 1);
          n_ticks = $urandom_range(1, 6);
          for (i = 0; i < k; i++) begin
            j = JW'(base_j + i);
            goal_pos[j] = ($urandom_range(0, 7) == 0) ? 32'($urandom) : near_pos(cmd_hist[j]);
          end
          for (t = 0; t < n_ticks; t++) begin
            for (i = 0; i < k; i++) begin
              send_word(tick_word(JW'(base_j + i), t == 0 && i == 0, i == k - 1));
              sent++;
            end
          end
        end
      endcase
    end
    await_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Rails of every signed field, max gains, torque passthrough and a zero cap.
  task automatic test_extremes();
    sample_t s;
    s = plain_word(jpsi_pkg::MODE_CAPTURE, 5'd0);
    s.meas = 32'sh8000_0000;
    s.ref_new = 1'b1;
    send_word(s);
    s = plain_word(jpsi_pkg::MODE_CAPTURE, 5'd31);
    s.meas = 32'sh7FFF_FFFF;
    send_word(s);
    // full-scale swing both ways: velocities saturate, PD far past the cap
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd31);
    s.meas = 32'sh7FFF_FFFF;  s.target = 32'sh8000_0000;
    s.pg = '1;  s.dg = '1;  s.cap = '1;
    send_word(s);
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd0);
    s.meas = 32'sh8000_0000;  s.target = 32'sh7FFF_FFFF;
    s.pg = '1;  s.dg = '1;  s.cap = '1;
    send_word(s);
    // passthrough at both rails; most negative torque is one past -cap
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd0);
    s.tmode = 1'b1;  s.ref_tau = 32'sh8000_0000;  s.cap = '1;
    s.meas = 32'sh7FFF_FFFF;  s.target = 32'sh7FFF_FFFF;
    send_word(s);
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd31);
    s.tmode = 1'b1;  s.ref_tau = 32'sh7FFF_FFFF;  s.cap = '1;
    s.meas = 32'sh8000_0000;  s.target = 32'sh8000_0000;
    send_word(s);
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd0);
    s.tmode = 1'b1;  s.ref_tau = 32'sd12345;
    s.meas = 32'sh7FFF_FFFF;  s.target = 32'sh7FFF_FFFF;
    send_word(s);
    // zero gains, zero cap: exact zero, not a clamp
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd31);
    s.meas = 32'sh8000_0000;  s.target = 32'sh8000_0000;
    send_word(s);
    await_idle();
  endtask

  // Stepping toward the reference, counter running down to zero and holding,
  // reload and tick end on a capture, and a negative uneven step.
  task automatic test_interpolation();
    sample_t s;
    load_servo_config(3, 200);
    s = plain_word(jpsi_pkg::MODE_CAPTURE, 5'd5);
    s.meas = 32'sh0001_0000;  s.ref_new = 1'b1;  s.tick_end = 1'b1;
    send_word(s);
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd5);
    s.meas = 32'sh0001_0000;  s.target = 32'sh0004_0000;
    s.pg = 31'h0002_0000;  s.dg = 31'h0000_0100;  s.cap = '1;  s.tick_end = 1'b1;
    send_word(s);   // half way
    send_word(s);   // last step lands on target
    s.target = 32'sh0009_0000;
    send_word(s);   // no steps left: command holds
    s.target = -32'sd7;  s.ref_new = 1'b1;  s.tick_end = 1'b0;
    send_word(s);   // reload, truncation toward zero on a negative step
    await_idle();
  endtask

  // Zero rate kills both velocities; full rate saturates them; unit rate.
  task automatic test_rate_limits();
    sample_t s;
    load_servo_config(3, 0);
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd5);
    s.meas = 32'sh4000_0000;  s.target = 32'sh8000_0000;  s.ref_new = 1'b1;
    s.pg = 31'h0001_0000;  s.dg = '1;  s.cap = '1;
    send_word(s);
    await_idle();
    load_servo_config(3, 65535);
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd0);
    s.meas = 32'sh0100_0000;  s.target = 32'sh7000_0000;  s.ref_new = 1'b1;
    s.pg = 31'h0000_8000;  s.dg = 31'h0000_0010;  s.cap = 31'h4000_0000;
    send_word(s);
    await_idle();
    load_servo_config(1, 1);
    s = plain_word(jpsi_pkg::MODE_CONTROL, 5'd31);
    s.meas = -32'sd65536;  s.target = 32'sh0003_0000;  s.ref_new = 1'b1;
    s.pg = 31'h0001_0000;  s.dg = 31'h0001_0000;  s.cap = 31'h0010_0000;
    s.tick_end = 1'b1;
    send_word(s);
    await_idle();
  endtask

  // Output held off for a long stretch while the sender keeps offering, so the
  // servo stalls its input; afterwards the sender waits for the backlog.
  task automatic test_backpressure();
    int i;
    logic [JW-1:0] j;
    load_servo_config(2, 200);
    gaps_on = 1'b0;
    hold_order = HOLD_OFF;
    for (i = 0; i < 8; i++) begin
      j = (i % 3 == 0) ? 5'd0 : (i % 3 == 1) ? 5'd5 : 5'd31;
      goal_pos[j] = near_pos(cmd_hist[j]);
      send_word(tick_word(j, i == 0, i % 3 == 2));
    end
    await_idle();
  endtask

  task automatic test_random_traffic();
    load_servo_config(4, 200);
    gaps_on = 1'b1;
    random_phase(PHASE_WORDS);
    load_servo_config(1024, 65535);
    gaps_on = 1'b0;
    random_phase(PHASE_WORDS);
    load_servo_config(1, 1);
    gaps_on = 1'b1;
    random_phase(PHASE_WORDS);
    load_servo_config($urandom_range(2, 1023), $urandom_range(1, 65535));
    random_phase(PHASE_WORDS);
    load_servo_config(16, 1000);
    gaps_on = 1'b0;
    random_phase(PHASE_WORDS);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_idx              <= jpsi_pkg::REG_INTERP_STEPS;
    cfg_wdata            <= '0;
    samp_if.valid        <= 1'b0;
    samp_if.mode         <= jpsi_pkg::MODE_CONTROL;
    samp_if.joint_index  <= '0;
    samp_if.measured_pos <= '0;
    samp_if.target_pos   <= '0;
    samp_if.ref_is_new   <= 1'b0;
    samp_if.torque_mode  <= 1'b0;
    samp_if.ref_torque   <= '0;
    samp_if.p_gain       <= '0;
    samp_if.d_gain       <= '0;
    samp_if.torque_cap   <= '0;
    samp_if.tick_end     <= 1'b0;
    for (i = 0; i < NJ; i++) begin
      pos_hist[i]   = '0;
      cmd_hist[i]   = '0;
      hist_valid[i] = 1'b0;
      goal_pos[i]   = '0;
    end
    interp_steps_set = jpsi_pkg::INTERP_STEPS_RST;
    rate_set         = jpsi_pkg::CONTROL_RATE_RST;
    steps_remaining  = jpsi_pkg::INTERP_STEPS_RST;
    mismatches = 0;
    n_control  = 0;
    n_capture  = 0;
    n_clamped  = 0;
    n_settings = 0;
    hold_order = 0;
    burst_left = 0;
    gaps_on    = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_extremes();
    test_interpolation();
    test_rate_limits();
    test_backpressure();
    test_random_traffic();

    await_idle();
    repeat (TAIL_CYCLES) @(posedge clk);   // catch any stray torque word
    $display("Covered %0d control and %0d capture words (%0d clamped) over %0d settings,",
             n_control, n_capture, n_clamped, n_settings);
    $display("incl. step rails, zero rate, zero steps left and a %0d-cycle output hold-off.",
             HOLD_OFF);
    if (mismatches == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Torque sink: stall pattern of its own plus the long hold-off, and checks
  // each word taken against the oldest owed torque.
  // ---------------------------------------------------------------------------
  initial begin : torque_sink
    int style, style_left, stall_run, hold_left, cyc;
    torque_word_t exp_w;
    style      = 0;
    style_left = 0;
    stall_run  = 0;
    hold_left  = 0;
    cyc        = 0;
    drive_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (!rst && drive_if.valid && drive_if.ready) begin
        if (torque_due.size() == 0) begin
          mismatches++;
          $display("%0t: torque word with nothing owed: joint %0d torque %0d clamped %0b",
                   $time, drive_if.out_joint, drive_if.drive_torque, drive_if.was_clamped);
        end else begin
          exp_w = torque_due.pop_front();
          if (drive_if.out_joint !== exp_w.joint || drive_if.drive_torque !== exp_w.torque
              || drive_if.was_clamped !== exp_w.clamped) begin
            mismatches++;
            $display("%0t: mismatch exp joint %0d torque %0d clamp %0b, got %0d %0d %0b",
                     $time, exp_w.joint, exp_w.torque, exp_w.clamped,
                     drive_if.out_joint, drive_if.drive_torque, drive_if.was_clamped);
          end
        end
      end
      if (hold_order > 0) begin
        hold_left  = hold_order;
        hold_order = 0;
      end
      if (style_left == 0) begin
        style      = $urandom_range(0, 4);
        style_left = $urandom_range(64, 256);
      end else begin
        style_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        drive_if.ready <= 1'b0;
      end else begin
        case (style)
          0: drive_if.ready <= 1'b1;                          // never stalls
          1: drive_if.ready <= $urandom_range(0, 1);
          2: drive_if.ready <= ($urandom_range(0, 3) == 0);   // mostly stalled
          3: drive_if.ready <= ((cyc % 7) < 3);               // fixed rhythm
          default: begin                                      // occasional long stalls
            if (stall_run > 0) begin
              stall_run--;
              drive_if.ready <= 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
              stall_run = $urandom_range(5, 40);
              drive_if.ready <= 1'b0;
            end else begin
              drive_if.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Watchdog: ends the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst || (samp_if.valid && samp_if.ready) || (drive_if.valid && drive_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: timeout, no word moved for %0d cycles, %0d torques still owed",
                 $time, QUIET_LIMIT, torque_due.size());
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

endmodule

@@ sim.f @@
sv/jpsi_pkg.sv
sv/jpsi_if.sv
sv/jpsi_ram.sv
sv/jpsi_div.sv
sv/jpsi_mul.sv
sv/joint_pd_servo_interp.sv
bench/joint_pd_servo_interp_tb.sv
